@@ sv/sfs_pkg.sv @@
// Package for the stereo soft fold saturator: fixed formats, sine series
// constants and the flag struct that travels with each sample.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfs_pkg;

  localparam int GAIN_W = 15;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd8192;

  // Scaled magnitude u is Q.20 and never reaches 4.0, so 22 bits hold it.
  localparam int U_W    = 22;
  localparam int FRAC_W = 20;
  // Fourth root of u, Q.20, below 2^21.
  localparam int R_W    = 21;
  // Folded phase fraction, Q.20 in [0, 2^20].
  localparam int F_W    = 21;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0] FOLD_K_Q30  = 30'd1060485752;

  // Horner divisors of the sine series and floor(2^32 / divisor).
  localparam int SINE_TERMS = 5;
  localparam logic [6:0]  SINE_DIV   [SINE_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [29:0] SINE_RECIP [SINE_TERMS] =
    '{30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882};

  typedef struct packed {
    logic neg;
    logic zero;
  } sfs_flags_t;

endpackage
`default_nettype wire

@@ sv/sfs_isqrt.sv @@
// Pipelined integer square root, two result bits per register stage.
// Carries a side payload alongside; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sfs_isqrt #(
  parameter int RAD_W = 42,
  parameter int P_W   = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     rad,
  input  logic [P_W-1:0]       in_pay,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root,
  output logic [P_W-1:0]       out_pay
);

  localparam int R_W  = RAD_W / 2;
  localparam int NSTG = (R_W + 1) / 2;
  localparam int RM_W = R_W + 2;

  logic [NSTG:0]    vld;
  logic [RAD_W-1:0] rd [NSTG+1];
  logic [RM_W-1:0]  rm [NSTG+1];
  logic [R_W-1:0]   rt [NSTG+1];
  logic [P_W-1:0]   py [NSTG+1];

  assign vld[0] = in_valid;
  assign rd[0]  = rad;
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign py[0]  = in_pay;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [RAD_W-1:0] rd_next;
    logic [RM_W-1:0]  rm_next;
    logic [R_W-1:0]   rt_next;

    always_comb begin
      logic [RM_W-1:0] cur;
      logic [RM_W-1:0] trial;
      cur     = '0;
      trial   = '0;
      rd_next = rd[s];
      rm_next = rm[s];
      rt_next = rt[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < R_W) begin
          cur     = {rm_next[RM_W-3:0], rd_next[RAD_W-1 -: 2]};
          trial   = {rt_next, 2'b01};
          rd_next = {rd_next[RAD_W-3:0], 2'b00};
          if (cur >= trial) begin
            rm_next = cur - trial;
            rt_next = {rt_next[R_W-2:0], 1'b1};
          end else begin
            rm_next = cur;
            rt_next = {rt_next[R_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd[s+1] <= rd_next;
        rm[s+1] <= rm_next;
        rt[s+1] <= rt_next;
        py[s+1] <= py[s];
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign root      = rt[NSTG];
  assign out_pay   = py[NSTG];

  // Remainder of a finished root never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rm[NSTG] <= ((RM_W)'(rt[NSTG]) << 1)))
    else $error("sqrt remainder out of bound");

endmodule
`default_nettype wire

@@ sv/sfs_div.sv @@
// Pipelined restoring divider, two quotient bits per register stage.
// Requires num >> Q_W below den; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sfs_div #(
  parameter int N_W = 44,
  parameter int D_W = 21,
  parameter int Q_W = 29,
  parameter int P_W = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [N_W-1:0]   num,
  input  logic [D_W-1:0]   den,
  input  logic [P_W-1:0]   in_pay,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo,
  output logic [P_W-1:0]   out_pay
);

  localparam int NSTG = (Q_W + 1) / 2;

  logic [NSTG:0]  vld;
  logic [Q_W-1:0] lo [NSTG+1];
  logic [D_W-1:0] rm [NSTG+1];
  logic [Q_W-1:0] qt [NSTG+1];
  logic [D_W-1:0] dv [NSTG+1];
  logic [P_W-1:0] py [NSTG+1];

  assign vld[0] = in_valid;
  assign lo[0]  = num[Q_W-1:0];
  assign rm[0]  = D_W'(num[N_W-1:Q_W]);
  assign qt[0]  = '0;
  assign dv[0]  = den;
  assign py[0]  = in_pay;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [Q_W-1:0] lo_next;
    logic [D_W-1:0] rm_next;
    logic [Q_W-1:0] qt_next;

    always_comb begin
      logic [D_W:0] cur;
      cur     = '0;
      lo_next = lo[s];
      rm_next = rm[s];
      qt_next = qt[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < Q_W) begin
          cur     = {rm_next, lo_next[Q_W-1]};
          lo_next = {lo_next[Q_W-2:0], 1'b0};
          if (cur >= {1'b0, dv[s]}) begin
            rm_next = D_W'(cur - {1'b0, dv[s]});
            qt_next = {qt_next[Q_W-2:0], 1'b1};
          end else begin
            rm_next = D_W'(cur);
            qt_next = {qt_next[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo[s+1] <= lo_next;
        rm[s+1] <= rm_next;
        qt[s+1] <= qt_next;
        dv[s+1] <= dv[s];
        py[s+1] <= py[s];
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign quo       = qt[NSTG];
  assign out_pay   = py[NSTG];

  // A finished division leaves a remainder below the divisor.
  a_rem_lt_den: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (dv[NSTG] != '0)) |-> (rm[NSTG] < dv[NSTG]))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

@@ sv/sfs_sine.sv @@
// Quarter-wave sine pipeline: Taylor series through z^11 in Horner form, Q.30.
// Depends on sfs_pkg for the series constants.
`timescale 1ns / 1ps
`default_nettype none
module sfs_sine #(
  parameter int P_W = 23
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [20:0]     f,
  input  logic [P_W-1:0]  in_pay,
  output logic            out_valid,
  output logic [31:0]     sine,
  output logic [P_W-1:0]  out_pay
);
  import sfs_pkg::*;

  // Angle and its square.
  logic           v1, v2;
  logic [30:0]    z1, z_2;
  logic [31:0]    z2_2;
  logic [P_W-1:0] pay1, pay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1   <= 31'((52'(f) * 52'(HALF_PI_Q30)) >> 20);
      pay1 <= in_pay;
      z_2  <= z1;
      z2_2 <= 32'((62'(z1) * 62'(z1)) >> 30);
      pay2 <= pay1;
    end
  end

  logic [SINE_TERMS:0] tv;
  logic [30:0]    tz  [SINE_TERMS+1];
  logic [31:0]    tz2 [SINE_TERMS+1];
  logic [30:0]    tp  [SINE_TERMS+1];
  logic [P_W-1:0] tpay[SINE_TERMS+1];

  assign tv[0]   = v2;
  assign tz[0]   = z_2;
  assign tz2[0]  = z2_2;
  assign tp[0]   = Q30_ONE;
  assign tpay[0] = pay2;

  // Each term: product, reciprocal estimate, correct and subtract from one.
  for (genvar i = 0; i < SINE_TERMS; i++) begin : g_term
    logic           va, vb;
    logic [30:0]    za, zb;
    logic [31:0]    z2a, z2b;
    logic [P_W-1:0] paya, payb;
    logic [31:0]    qa, qb;
    logic [29:0]    qeb;
    logic [31:0]    back;
    logic [31:0]    rem;
    logic [29:0]    quot;

    assign back = 32'(qeb) * 32'(SINE_DIV[i]);
    assign rem  = qb - back;
    assign quot = (rem >= 32'(SINE_DIV[i])) ? qeb + 30'd1 : qeb;

    always_ff @(posedge clk) begin
      if (rst) begin
        va      <= 1'b0;
        vb      <= 1'b0;
        tv[i+1] <= 1'b0;
      end else if (en) begin
        va      <= tv[i];
        vb      <= va;
        tv[i+1] <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qa        <= 32'((63'(tz2[i]) * 63'(tp[i])) >> 30);
        za        <= tz[i];
        z2a       <= tz2[i];
        paya      <= tpay[i];
        qb        <= qa;
        qeb       <= 30'((62'(qa) * 62'(SINE_RECIP[i])) >> 32);
        zb        <= za;
        z2b       <= z2a;
        payb      <= paya;
        tp[i+1]   <= Q30_ONE - 31'(quot);
        tz[i+1]   <= zb;
        tz2[i+1]  <= z2b;
        tpay[i+1] <= payb;
      end
    end
  end

  logic           vo;
  logic [31:0]    so;
  logic [P_W-1:0] payo;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= tv[SINE_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so   <= 32'((62'(tz[SINE_TERMS]) * 62'(tp[SINE_TERMS])) >> 30);
      payo <= tpay[SINE_TERMS];
    end
  end

  assign out_valid = vo;
  assign sine      = so;
  assign out_pay   = payo;

endmodule
`default_nettype wire

@@ sv/sfs_chan.sv @@
// One channel of the saturator: gain, fourth root, fold phase, sine, divide
// and saturate. Depends on sfs_pkg, sfs_isqrt, sfs_sine and sfs_div.
`timescale 1ns / 1ps
`default_nettype none
module sfs_chan #(
  parameter int W = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [W-1:0]        sample,
  input  logic [sfs_pkg::GAIN_W-1:0] gain,
  output logic                       out_valid,
  output logic signed [W-1:0]        result
);
  import sfs_pkg::*;

  localparam int FL_W  = $bits(sfs_flags_t);
  localparam int PR_W  = W + GAIN_W;
  localparam int RAD_W = 2 * R_W;
  localparam int N_W   = W + 20;
  localparam int Q_W   = W + 5;

  // Magnitude and sign.
  logic           va, vb, vc;
  logic [W-1:0]   mag_a;
  logic           neg_a, neg_b;
  logic [PR_W-1:0] prod_b;
  logic [U_W-1:0] u_c;
  sfs_flags_t     fl_c;
  logic [PR_W-1:0] sum_b;
  logic [U_W-1:0] u_next;

  assign sum_b  = prod_b + ((PR_W)'(1) << (W - 9));
  assign u_next = U_W'(sum_b >> (W - 8));

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a     <= sample[W-1];
      mag_a     <= sample[W-1] ? W'(-$unsigned(sample)) : $unsigned(sample);
      neg_b     <= neg_a;
      prod_b    <= (PR_W)'(mag_a) * (PR_W)'(gain);
      u_c       <= u_next;
      fl_c.neg  <= neg_b;
      fl_c.zero <= (u_next == '0);
    end
  end

  // Fourth root as two square roots.
  logic               v_s1, v_s2;
  logic [R_W-1:0]     r1, r2;
  logic [U_W+FL_W-1:0] pay_s1, pay_s2;

  sfs_isqrt #(.RAD_W(RAD_W), .P_W(U_W + FL_W)) u_sqrt1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc),
    .rad({u_c, FRAC_W'(0)}), .in_pay({u_c, fl_c}),
    .out_valid(v_s1), .root(r1), .out_pay(pay_s1)
  );

  sfs_isqrt #(.RAD_W(RAD_W), .P_W(U_W + FL_W)) u_sqrt2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_s1),
    .rad({1'b0, r1, FRAC_W'(0)}), .in_pay(pay_s1),
    .out_valid(v_s2), .root(r2), .out_pay(pay_s2)
  );

  // Phase t = u * r, then fold into the first quadrant.
  logic           vt, vf;
  logic [22:0]    t_t;
  logic [R_W-1:0] r_t, r_f;
  sfs_flags_t     fl_t, fl_f;
  logic [F_W-1:0] f_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
      vf <= 1'b0;
    end else if (en) begin
      vt <= v_s2;
      vf <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_t       <= 23'((43'(pay_s2[U_W+FL_W-1:FL_W]) * 43'(r2)) >> FRAC_W);
      r_t       <= r2;
      fl_t      <= pay_s2[FL_W-1:0];
      f_f       <= t_t[20] ? (F_W)'(1 << FRAC_W) - {1'b0, t_t[19:0]}
                           : {1'b0, t_t[19:0]};
      r_f       <= r_t;
      fl_f.neg  <= fl_t.neg ^ t_t[21];
      fl_f.zero <= fl_t.zero;
    end
  end

  logic                v_sn;
  logic [31:0]         sn;
  logic [R_W+FL_W-1:0] pay_sn;

  sfs_sine #(.P_W(R_W + FL_W)) u_sine (
    .clk(clk), .rst(rst), .en(en), .in_valid(vf),
    .f(f_f), .in_pay({r_f, fl_f}),
    .out_valid(v_sn), .sine(sn), .out_pay(pay_sn)
  );

  // Clamp the sine and apply the fold constant.
  logic           vm;
  logic [29:0]    m_m;
  logic [R_W-1:0] r_m;
  sfs_flags_t     fl_m;
  logic [30:0]    s_cl;
  logic [N_W-1:0] numer;

  assign s_cl  = (sn > 32'(Q30_ONE)) ? Q30_ONE : sn[30:0];
  assign numer = ((N_W)'(m_m) << (W - 11)) + (N_W)'(r_m >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= v_sn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_m  <= 30'((61'(s_cl) * 61'(FOLD_K_Q30)) >> 30);
      r_m  <= pay_sn[R_W+FL_W-1:FL_W];
      fl_m <= pay_sn[FL_W-1:0];
    end
  end

  logic           v_d;
  logic [Q_W-1:0] y_d;
  sfs_flags_t     fl_d;

  sfs_div #(.N_W(N_W), .D_W(R_W), .Q_W(Q_W), .P_W(FL_W)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vm),
    .num(numer), .den(r_m), .in_pay(fl_m),
    .out_valid(v_d), .quo(y_d), .out_pay(fl_d)
  );

  // Saturate and apply the sign.
  localparam logic [Q_W-1:0] SBIT = (Q_W)'(1) << (W - 1);

  logic           vo;
  logic [W-1:0]   res_next, res_o;
  logic [Q_W-1:0] y_cl;

  always_comb begin
    y_cl     = '0;
    res_next = '0;
    if (fl_d.zero) begin
      res_next = '0;
    end else if (fl_d.neg) begin
      y_cl     = (y_d > SBIT) ? SBIT : y_d;
      res_next = W'((Q_W)'(0) - y_cl);
    end else begin
      y_cl     = (y_d > SBIT - 1'b1) ? SBIT - 1'b1 : y_d;
      res_next = W'(y_cl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_o <= res_next;
    end
  end

  assign out_valid = vo;
  assign result    = $signed(res_o);

endmodule
`default_nettype wire

@@ sv/stereo_soft_fold_saturator_core.sv @@
// Stereo soft fold saturator: a programmable gain stage followed by the
// shaping curve y = 0.987654321 * sin(x * r * pi/2) / r, r = |x|^(1/4),
// on each channel of a stereo frame. The block takes one stereo frame per
// clock and returns one shaped frame per clock while the output is not
// stalled; each frame passes the gain stage, the two pipelined square roots
// (two root bits per stage), the phase fold, the five-term sine pipeline,
// the final pipelined divider (two quotient bits per stage) and the output
// saturation register. The whole pipe advances together
// when the output register is empty or being taken, so in_ready drops only
// while a finished frame waits. The gain register (unsigned Q3.13) is
// written by cfg_we/cfg_data and should only change while the pipe is empty.
// Depends on sfs_pkg and sfs_chan.
`timescale 1ns / 1ps
`default_nettype none
module stereo_soft_fold_saturator_core #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    left_in,
  input  logic signed [SAMPLE_WIDTH-1:0]    right_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    left_out,
  output logic signed [SAMPLE_WIDTH-1:0]    right_out,
  input  logic                              cfg_we,
  input  logic [sfs_pkg::GAIN_W-1:0]        cfg_data
);
  import sfs_pkg::*;

  // Gain register, written directly from the config port.
  logic [GAIN_W-1:0] gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_data;
    end
  end

  // Advance the pipe unless a finished frame is stuck at the output.
  logic en;
  logic l_valid, r_valid;

  assign en       = !l_valid || out_ready;
  assign in_ready = en;

  sfs_chan #(.W(SAMPLE_WIDTH)) u_left (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .sample(left_in), .gain(gain),
    .out_valid(l_valid), .result(left_out)
  );

  sfs_chan #(.W(SAMPLE_WIDTH)) u_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .sample(right_in), .gain(gain),
    .out_valid(r_valid), .result(right_out)
  );

  assign out_valid = l_valid;

  // Both channel pipes must carry the same transaction in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    l_valid == r_valid)
    else $error("left and right pipes out of step");

  // Reset must drain every stage, including the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A held output frame must block new transactions.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (l_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule
`default_nettype wire
